### design/pfa_pkg.sv
package pfa_pkg;

    // Default table geometry
    localparam int MAX_PARTS_DEF = 16;
    localparam int SIZE_BITS_DEF = 16;

    // Fixed field widths
    localparam int PART_INDEX_W = 4;
    localparam int REQ_SIZE_W   = 16;
    localparam int REQ_NUM_W    = 16;
    localparam int POLICY_W     = 2;
    localparam int BLOCKS_W     = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 5;

    // Reset values of the configuration registers
    localparam logic [POLICY_W-1:0] POLICY_RESET = 2'd0;
    localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 5'd16;

    // Fit policy codes; the unused code behaves as first fit
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

    // Item type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic scan;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_alloc;
        logic limit_zero;
        logic scan_last;
    } t_status;

endpackage

### design/pfa_ctrl.sv
module pfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pfa_pkg::t_status i_sts,
    output pfa_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_sts.is_alloc && !i_sts.limit_zero) ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive commands from the current state
    assign o_busy        = (r_state != S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_start;
    assign o_cmd.scan    = (r_state == S_SCAN);
    assign o_cmd.finish  = (r_state == S_FINISH);

    // The drain state, which evaluates the last scan read, is only entered from the scan state
    a_drain_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> $past(r_state == S_SCAN))
        else $error("drain entered without a scan");

    // Leaving busy only happens through the finish state
    a_busy_ends_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> $past(o_cmd.finish))
        else $error("busy dropped without finishing the transaction");

endmodule

### design/pfa_datapath.sv
module pfa_datapath #(
    parameter int MAX_PARTS = pfa_pkg::MAX_PARTS_DEF,
    parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_req_type,
    input  logic [pfa_pkg::PART_INDEX_W-1:0]   i_part_index,
    input  logic [pfa_pkg::REQ_SIZE_W-1:0]     i_req_size,
    input  pfa_pkg::t_cmd                      i_cmd,
    output pfa_pkg::t_status                   o_sts,
    output logic                               o_valid,
    output logic                               o_granted,
    output logic [pfa_pkg::PART_INDEX_W-1:0]   o_chosen_part,
    output logic [pfa_pkg::REQ_NUM_W-1:0]      o_request_number
);

    localparam int IDX_W = $clog2(MAX_PARTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (SIZE_BITS > pfa_pkg::REQ_SIZE_W) ? SIZE_BITS : pfa_pkg::REQ_SIZE_W;
    localparam int PI_W  = pfa_pkg::PART_INDEX_W;

    // Configuration registers
    logic [pfa_pkg::POLICY_W-1:0] r_fit_policy;
    logic [pfa_pkg::BLOCKS_W-1:0] r_blocks_in_use;

    // Partition table: sizes in memory, written/used marks in flops
    logic [SIZE_BITS-1:0] mem_size [MAX_PARTS];
    logic [MAX_PARTS-1:0] r_written;
    logic [MAX_PARTS-1:0] r_used;

    // Captured transaction
    logic                          r_req_type;
    logic [PI_W-1:0]               r_part_index;
    logic [pfa_pkg::REQ_SIZE_W-1:0] r_req_size;
    logic [CNT_W-1:0]              r_limit;

    // Scan state
    logic [CNT_W-1:0]     r_scan_idx;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic                 r_rd_written;
    logic                 r_rd_used;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [SIZE_BITS-1:0] r_best_size;

    logic [pfa_pkg::REQ_NUM_W-1:0] r_req_count;

    // Result registers
    logic                           r_out_valid;
    logic                           r_out_granted;
    logic [PI_W-1:0]                r_out_part;
    logic [pfa_pkg::REQ_NUM_W-1:0]  r_out_num;

    logic [CNT_W-1:0]      w_limit;
    logic [CNT_W-1:0]      w_scan_next;
    logic [IDX_W-1:0]      w_scan_addr;
    logic [IDX_W+PI_W-1:0] w_ld_ext;
    logic [IDX_W-1:0]      w_ld_addr;
    logic                  w_ld_ok;
    logic [CMP_W-1:0]      w_need;
    logic [SIZE_BITS-1:0]  w_ld_size;
    logic [SIZE_BITS-1:0]  w_eff_size;
    logic                  w_fits;
    logic                  w_take;
    logic [IDX_W+PI_W-1:0] w_best_ext;

    // Saturate the partition count to the table depth
    assign w_limit = ($unsigned(32'(r_blocks_in_use)) > $unsigned(32'(MAX_PARTS)))
                     ? CNT_W'(MAX_PARTS) : CNT_W'(r_blocks_in_use);

    assign w_scan_next = r_scan_idx + 1'b1;
    assign w_scan_addr = r_scan_idx[IDX_W-1:0];

    assign o_sts.is_alloc   = (i_req_type == pfa_pkg::REQ_ALLOC);
    assign o_sts.limit_zero = (w_limit == '0);
    assign o_sts.scan_last  = (w_scan_next == r_limit);

    // Load address and size, masked to the table
    assign w_ld_ext  = {{IDX_W{1'b0}}, r_part_index};
    assign w_ld_addr = w_ld_ext[IDX_W-1:0];
    assign w_ld_ok   = ($unsigned(32'(r_part_index)) < $unsigned(32'(MAX_PARTS)));
    assign w_need    = CMP_W'(r_req_size);
    assign w_ld_size = w_need[SIZE_BITS-1:0];

    // Evaluate the entry read in the previous cycle
    assign w_eff_size = r_rd_written ? r_rd_data : '0;
    assign w_fits     = !r_rd_used && (CMP_W'(w_eff_size) >= w_need);

    always_comb begin
        w_take = 1'b0;
        if (w_fits) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else begin
                case (r_fit_policy)
                    pfa_pkg::POLICY_BEST:  w_take = (w_eff_size < r_best_size);
                    pfa_pkg::POLICY_WORST: w_take = (w_eff_size > r_best_size);
                    default:               w_take = 1'b0;
                endcase
            end
        end
    end

    assign w_best_ext = {{PI_W{1'b0}}, r_best_idx};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy    <= pfa_pkg::POLICY_RESET;
            r_blocks_in_use <= pfa_pkg::BLOCKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pfa_pkg::CFG_FIT_POLICY:    r_fit_policy    <= i_cfg_data[pfa_pkg::POLICY_W-1:0];
                pfa_pkg::CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data[pfa_pkg::BLOCKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Size memory: write on load finish, read one entry per scan cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && (r_req_type == pfa_pkg::REQ_LOAD) && w_ld_ok) begin
            mem_size[w_ld_addr] <= w_ld_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_data <= mem_size[w_scan_addr];
        end
    end

    // Capture the transaction and hold read side info
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type   <= i_req_type;
            r_part_index <= i_part_index;
            r_req_size   <= i_req_size;
            r_limit      <= w_limit;
        end
        if (i_cmd.scan) begin
            r_rd_idx     <= w_scan_addr;
            r_rd_written <= r_written[w_scan_addr];
            r_rd_used    <= r_used[w_scan_addr];
        end
        if (r_rd_vld && w_take) begin
            r_best_idx  <= r_rd_idx;
            r_best_size <= w_eff_size;
        end
        if (i_cmd.finish) begin
            r_out_granted <= (r_req_type == pfa_pkg::REQ_ALLOC) && r_found;
            r_out_part    <= ((r_req_type == pfa_pkg::REQ_ALLOC) && r_found)
                             ? w_best_ext[PI_W-1:0] : '0;
            r_out_num     <= (r_req_type == pfa_pkg::REQ_ALLOC) ? r_req_count : '0;
        end
    end

    // Scan control, marks and request counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_used      <= '0;
            r_scan_idx  <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_req_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld    <= i_cmd.scan;
            r_out_valid <= i_cmd.finish;
            if (i_cmd.capture) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end else if (i_cmd.scan) begin
                r_scan_idx <= w_scan_next;
            end
            if (r_rd_vld && w_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_req_type == pfa_pkg::REQ_LOAD) begin
                    if (w_ld_ok) begin
                        r_written[w_ld_addr] <= 1'b1;
                        r_used[w_ld_addr]    <= 1'b0;
                    end
                end else begin
                    r_req_count <= r_req_count + 1'b1;
                    if (r_found) begin
                        r_used[r_best_idx] <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_granted        = r_out_granted;
    assign o_chosen_part    = r_out_part;
    assign o_request_number = r_out_num;

    // A read result only appears right after a scan command
    a_read_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.scan))
        else $error("read data flagged without a scan");

    // A found partition always lies within the searched range
    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_cmd.capture) |-> (CNT_W'(r_best_idx) < r_limit))
        else $error("selected partition outside the search range");

endmodule

### design/partition_fit_allocator.sv
// Partition fit allocator.
// A load, or a request with no partition to search, goes from idle to the finish
// state; any other request first scans the partitions searched, one entry per
// cycle, then passes the drain state before finishing. A new request is taken
// only when the block is idle again. Reset (synchronous, active low) frees every
// partition, makes every size read as zero and zeroes the count.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
module partition_fit_allocator #(
    parameter int MAX_PARTS = pfa_pkg::MAX_PARTS_DEF,
    parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_req_type,
    input  logic [pfa_pkg::PART_INDEX_W-1:0]  i_part_index,
    input  logic [pfa_pkg::REQ_SIZE_W-1:0]    i_req_size,
    output logic                              o_valid,
    output logic                              o_granted,
    output logic [pfa_pkg::PART_INDEX_W-1:0]  o_chosen_part,
    output logic [pfa_pkg::REQ_NUM_W-1:0]     o_request_number
);

    pfa_pkg::t_cmd    w_cmd;
    pfa_pkg::t_status w_sts;

    // Sequence the transaction
    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Table, search and result registers
    pfa_datapath #(
        .MAX_PARTS (MAX_PARTS),
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_part_index     (i_part_index),
        .i_req_size       (i_req_size),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_valid          (o_valid),
        .o_granted        (o_granted),
        .o_chosen_part    (o_chosen_part),
        .o_request_number (o_request_number)
    );

endmodule

### bench/partition_fit_allocator_tb.sv
module partition_fit_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One reply of the allocator, packed in port order
    typedef struct packed {
        logic                             granted;
        logic [pfa_pkg::PART_INDEX_W-1:0] part;
        logic [pfa_pkg::REQ_NUM_W-1:0]    number;
    } t_grant;

    // Mirror of the partition table; predicts the reply to every transaction
    class t_alloc_ledger;
        logic [pfa_pkg::POLICY_W-1:0]   policy;
        logic [pfa_pkg::BLOCKS_W-1:0]   span;
        logic [pfa_pkg::REQ_SIZE_W-1:0] sizes [pfa_pkg::MAX_PARTS_DEF];
        bit                             used [pfa_pkg::MAX_PARTS_DEF];
        logic [pfa_pkg::REQ_NUM_W-1:0]  req_count;
        t_grant                         grants_due [$];
        int errors;
        int loads;
        int requests;
        int granted;
        int replies;

        function void clear();
            policy    = pfa_pkg::POLICY_RESET;
            span      = pfa_pkg::BLOCKS_RESET;
            req_count = '0;
            for (int i = 0; i < pfa_pkg::MAX_PARTS_DEF; i++) begin
                sizes[i] = '0;
                used[i]  = 1'b0;
            end
            grants_due.delete();
            errors   = 0;
            loads    = 0;
            requests = 0;
            granted  = 0;
            replies  = 0;
        endfunction

        function void write_register(logic [pfa_pkg::CFG_INDEX_W-1:0] index,
                                     logic [pfa_pkg::CFG_DATA_W-1:0] data);
            if (index == pfa_pkg::CFG_FIT_POLICY) begin
                policy = data[pfa_pkg::POLICY_W-1:0];
            end else begin
                span = data[pfa_pkg::BLOCKS_W-1:0];
            end
        endfunction

        // Apply one accepted transaction and queue the reply it must produce
        function void record_item(logic kind, logic [pfa_pkg::PART_INDEX_W-1:0] slot,
                                  logic [pfa_pkg::REQ_SIZE_W-1:0] size);
            t_grant reply;
            int     limit;
            int     pick;
            bit     found;
            bit     stop;
            reply = '0;
            if (kind == pfa_pkg::REQ_LOAD) begin
                sizes[slot] = size;
                used[slot]  = 1'b0;
                loads++;
            end else begin
                reply.number = req_count;
                req_count++;
                requests++;
                limit = (span > pfa_pkg::MAX_PARTS_DEF) ? pfa_pkg::MAX_PARTS_DEF : span;
                found = 1'b0;
                stop  = 1'b0;
                pick  = 0;
                // Scan free partitions that are large enough; ties keep the lower index
                for (int i = 0; i < limit; i++) begin
                    if (!stop && !used[i] && sizes[i] >= size) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = i;
                            stop  = (policy != pfa_pkg::POLICY_BEST)
                                    && (policy != pfa_pkg::POLICY_WORST);
                        end else if (policy == pfa_pkg::POLICY_BEST
                                     && sizes[i] < sizes[pick]) begin
                            pick = i;
                        end else if (policy == pfa_pkg::POLICY_WORST
                                     && sizes[i] > sizes[pick]) begin
                            pick = i;
                        end
                    end
                end
                if (found) begin
                    used[pick]    = 1'b1;
                    reply.granted = 1'b1;
                    reply.part    = pick[pfa_pkg::PART_INDEX_W-1:0];
                    granted++;
                end
            end
            grants_due.push_back(reply);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        // Compare one strobed reply with the oldest prediction
        function void match_grant(t_grant got);
            t_grant want;
            replies++;
            if (grants_due.size() == 0) begin
                errors++;
                $display("%0t: reply with nothing pending, expected none actual %0d/%0d/%0d",
                         $time, got.granted, got.part, got.number);
                return;
            end
            want = grants_due.pop_front();
            compare_field("granted", 32'(want.granted), 32'(got.granted));
            compare_field("chosen_part", 32'(want.part), 32'(got.part));
            compare_field("request_number", 32'(want.number), 32'(got.number));
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [pfa_pkg::CFG_INDEX_W-1:0]  i_cfg_index;
    logic [pfa_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             start;
    logic                             busy;
    logic                             i_req_type;
    logic [pfa_pkg::PART_INDEX_W-1:0] i_part_index;
    logic [pfa_pkg::REQ_SIZE_W-1:0]   i_req_size;
    logic                             o_valid;
    logic                             o_granted;
    logic [pfa_pkg::PART_INDEX_W-1:0] o_chosen_part;
    logic [pfa_pkg::REQ_NUM_W-1:0]    o_request_number;

    t_alloc_ledger ledger;
    bit            no_idle;
    int            phases_run;

    partition_fit_allocator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_part_index     (i_part_index),
        .i_req_size       (i_req_size),
        .o_valid          (o_valid),
        .o_granted        (o_granted),
        .o_chosen_part    (o_chosen_part),
        .o_request_number (o_request_number)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check every strobed reply at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            ledger.match_grant({o_granted, o_chosen_part, o_request_number});
        end
    end

    // Present one transaction after a random gap and hold it until taken
    task automatic send_item(logic kind, logic [pfa_pkg::PART_INDEX_W-1:0] slot,
                             logic [pfa_pkg::REQ_SIZE_W-1:0] size);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            no_idle = !no_idle;
        end
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= kind;
        i_part_index <= slot;
        i_req_size   <= size;
        do @(posedge i_clk); while (busy);
        ledger.record_item(kind, slot, size);
    endtask

    // Drop start and wait until every reply is in and the block is idle
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (ledger.grants_due.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges, then release the port
    task automatic configure(logic [pfa_pkg::POLICY_W-1:0] pol,
                             logic [pfa_pkg::BLOCKS_W-1:0] count);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pfa_pkg::CFG_FIT_POLICY;
        i_cfg_data  <= pfa_pkg::CFG_DATA_W'(pol);
        @(posedge i_clk);
        ledger.write_register(pfa_pkg::CFG_FIT_POLICY, pfa_pkg::CFG_DATA_W'(pol));
        i_cfg_index <= pfa_pkg::CFG_BLOCKS_IN_USE;
        i_cfg_data  <= count;
        @(posedge i_clk);
        ledger.write_register(pfa_pkg::CFG_BLOCKS_IN_USE, count);
        i_cfg_we <= 1'b0;
    endtask

    // Mix of full-range sizes, coarse sizes that tie often, tiny sizes and extremes
    function automatic logic [pfa_pkg::REQ_SIZE_W-1:0] draw_size();
        logic [pfa_pkg::REQ_SIZE_W-1:0] size;
        case ($urandom_range(0, 3))
            0: size = pfa_pkg::REQ_SIZE_W'($urandom_range(0, 65535));
            1: size = pfa_pkg::REQ_SIZE_W'($urandom_range(0, 7)) << 13;
            2: size = pfa_pkg::REQ_SIZE_W'($urandom_range(0, 15));
            default: size = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return size;
    endfunction

    // Requests with loads that free partitions, and now and then a full table refill
    task automatic run_random(int count);
        int issued;
        issued = 0;
        while (issued < count) begin
            if ($urandom_range(0, 24) == 0) begin
                for (int p = 0; p < pfa_pkg::MAX_PARTS_DEF; p++) begin
                    send_item(pfa_pkg::REQ_LOAD, pfa_pkg::PART_INDEX_W'(p), draw_size());
                end
                issued += pfa_pkg::MAX_PARTS_DEF;
            end else begin
                send_item(($urandom_range(0, 99) < 38) ? pfa_pkg::REQ_LOAD : pfa_pkg::REQ_ALLOC,
                          pfa_pkg::PART_INDEX_W'($urandom_range(0, 15)), draw_size());
                issued++;
            end
        end
    endtask

    initial begin
        logic [pfa_pkg::BLOCKS_W-1:0] spans [14];
        spans = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd16,
                  5'd2, 5'd15, 5'd3, 5'd16, 5'd24, 5'd5, 5'd16};
        ledger = new();
        ledger.clear();
        no_idle      = 1'b0;
        phases_run   = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        start        = 1'b0;
        i_req_type   = pfa_pkg::REQ_LOAD;
        i_part_index = '0;
        i_req_size   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table under reset settings: zero-size request fits, size 1 does not
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd0);
        send_item(pfa_pkg::REQ_ALLOC, 4'd15, 16'd1);
        send_item(pfa_pkg::REQ_LOAD, 4'd15, 16'hFFFF);
        send_item(pfa_pkg::REQ_LOAD, 4'd0, 16'd0);
        send_item(pfa_pkg::REQ_LOAD, 4'd1, 16'd100);
        send_item(pfa_pkg::REQ_LOAD, 4'd2, 16'd50);
        send_item(pfa_pkg::REQ_LOAD, 4'd3, 16'd100);
        send_item(pfa_pkg::REQ_LOAD, 4'd4, 16'hFFFF);
        send_item(pfa_pkg::REQ_ALLOC, 4'd9, 16'hFFFF);

        // Best fit with a size tie, then the smallest free partition
        configure(pfa_pkg::POLICY_BEST, 5'd16);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd60);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd60);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd0);

        // Worst fit with an oversized partition count until nothing fits
        configure(pfa_pkg::POLICY_WORST, 5'd31);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd1);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd1);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd1);

        // Unused policy code; zero partitions searched, then only the first
        configure(2'd3, 5'd0);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd0);
        send_item(pfa_pkg::REQ_LOAD, 4'd1, 16'd7);
        configure(2'd3, 5'd1);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'd0);
        send_item(pfa_pkg::REQ_LOAD, 4'd0, 16'hFFFF);
        send_item(pfa_pkg::REQ_ALLOC, 4'd0, 16'hFFFF);

        // Random phases, cycling the policy code and stepping through a list of partition counts
        for (int ph = 0; ph < 14; ph++) begin
            configure(pfa_pkg::POLICY_W'(ph), spans[ph]);
            run_random(131);
            phases_run++;
        end

        settle();
        repeat (25) @(posedge i_clk);
        $display("Covered %0d loads and %0d requests (%0d granted) over %0d random phases,",
                 ledger.loads, ledger.requests, ledger.granted, phases_run);
        $display("all four policy codes and partition counts from 0 to 31; %0d replies checked.",
                 ledger.replies);
        if (ledger.errors == 0 && ledger.grants_due.size() == 0) begin
            $display("partition_fit_allocator_tb OK");
        end else begin
            $display("partition_fit_allocator_tb NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5ms;
        $display("partition_fit_allocator_tb NOT OK");
        $finish;
    end

endmodule

### sim.f
design/pfa_pkg.sv
design/pfa_ctrl.sv
design/pfa_datapath.sv
design/partition_fit_allocator.sv
bench/partition_fit_allocator_tb.sv
